// ===== hw/rtl/cle_pkg.sv =====
// Shared types and character codes of the console line editor.
`default_nettype none

package cle_pkg;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_EOF       = 8'h04;
   localparam logic [7:0] CHAR_KILL      = 8'h15;

   localparam int unsigned LINE_LEN_MAX  = 1024;

   typedef struct packed {
      logic accept;
      logic read;
      logic advance;
   } cle_cmd_type;

   typedef struct packed {
      logic flush;
      logic last;
   } cle_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cle_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cle_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cle_ctrl.sv =====
// Controller state machine of the console line editor.
`default_nettype none

module cle_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire cle_pkg::cle_status_type status,
   output cle_pkg::cle_cmd_type        cmd
);
   import cle_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SHOW = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && status.flush) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cle_datapath.sv =====
// Datapath of the console line editor: line store, fill index and read-out.
`default_nettype none

module cle_datapath #(
   parameter int unsigned LINE_LEN = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cle_pkg::cle_cmd_type cmd,
   output cle_pkg::cle_status_type   status,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 csr_we,
   input  wire logic                 csr_wdata,
   output logic      [7:0]           rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import cle_pkg::*;

   localparam int unsigned IDX_W = $clog2(LINE_LEN);

   logic             raw_mode_ff;
   logic [IDX_W-1:0] fill_ff;
   logic [IDX_W-1:0] fill_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] rd_idx_in;
   logic [IDX_W-1:0] last_idx_ff;
   logic [IDX_W-1:0] last_idx_in;
   logic             empty_ff;
   logic             empty_in;
   logic             wr_en;
   logic             flush;
   logic             full;
   logic             is_eol;
   logic [7:0]       rd_data;

   assign full   = (fill_ff == IDX_W'(LINE_LEN - 1));
   assign is_eol = req_tdata inside {CHAR_NEWLINE, CHAR_EOF};

   always_comb begin
      flush       = 1'b0;
      wr_en       = 1'b0;
      fill_in     = fill_ff;
      last_idx_in = last_idx_ff;
      empty_in    = empty_ff;
      rd_idx_in   = rd_idx_ff;
      if (raw_mode_ff) begin
         flush       = 1'b1;
         wr_en       = 1'b1;
         fill_in     = '0;
         last_idx_in = fill_ff;
         empty_in    = 1'b0;
      end else if (req_tdata == CHAR_BACKSPACE) begin
         if (fill_ff != '0) begin
            fill_in = fill_ff - IDX_W'(1);
         end
      end else if (req_tdata == CHAR_KILL) begin
         fill_in = '0;
      end else begin
         wr_en = 1'b1;
         if (is_eol || full) begin
            flush   = 1'b1;
            fill_in = '0;
            if (req_tdata == CHAR_EOF) begin
               empty_in    = (fill_ff == '0);
               last_idx_in = fill_ff - IDX_W'(1);
            end else begin
               empty_in    = 1'b0;
               last_idx_in = fill_ff;
            end
         end else begin
            fill_in = fill_ff + IDX_W'(1);
         end
      end
      if (cmd.accept) begin
         rd_idx_in = '0;
      end else begin
         fill_in     = fill_ff;
         last_idx_in = last_idx_ff;
         empty_in    = empty_ff;
         if (cmd.advance) begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         if (csr_we) begin
            raw_mode_ff <= csr_wdata;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      empty_ff    <= empty_in;
   end

   cle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_LEN)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en && cmd.accept),
      .wr_addr (fill_ff),
      .wr_data (req_tdata),
      .rd_en   (cmd.read),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign status.flush = flush;
   assign status.last  = empty_ff || (rd_idx_ff == last_idx_ff);

   assign rsp_tdata = empty_ff ? 8'h00 : rd_data;
   assign rsp_tlast = status.last;
   assign rsp_tuser = empty_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/console_line_editor.sv =====
// Top level of the console line editor.
//
//   Channel  Direction  Contents
//   req_     in         tdata[7:0] = in_byte
//   rsp_     out        tdata[7:0] = out_byte, tlast = last_of_line, tuser = empty_line
//   csr_     in         wdata = raw_mode
//
// A byte that causes no output is taken in the idle state. Each output byte of a flushed
// line goes through a read state, for the registered read of the line store, and then a
// show state. Requests are not taken while a line is being sent out. A stalled response
// holds. Reset is synchronous and clears the fill index, the mode and the state machine.
`default_nettype none

module console_line_editor #(
   parameter int unsigned LINE_LEN = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,
   output logic            rsp_tuser,   // [0] empty_line
   input  wire logic       csr_we,
   input  wire logic       csr_wdata
);
   import cle_pkg::*;

   cle_cmd_type    cmd;
   cle_status_type status;

   cle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cle_datapath #(
      .LINE_LEN (LINE_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/cle_checker.sv =====
// Port-level checker of the console line editor and its binding.
`default_nettype none

module cle_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("A stalled response changed.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("A request was offered while a line was being sent.");

   a_empty_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("An empty line response carried data or no last marker.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("A response appeared straight after reset.");

endmodule

bind console_line_editor cle_checker u_checker (.*);

`default_nettype wire
